@@ rtl/ght_pkg.sv @@
// Package for the generational handle table: request and status codes, slot marks,
// and the result and evaluation structs that the table modules share.
// No dependencies.
`default_nettype none
package ght_pkg;
	localparam logic [3:0] REQ_CREATE     = 4'd0;
	localparam logic [3:0] REQ_DESTROY    = 4'd1;
	localparam logic [3:0] REQ_COMMIT     = 4'd2;
	localparam logic [3:0] REQ_QUERY      = 4'd3;
	localparam logic [3:0] REQ_ADD_COMPS  = 4'd4;
	localparam logic [3:0] REQ_REM_COMPS  = 4'd5;
	localparam logic [3:0] REQ_SET_TAGS   = 4'd6;
	localparam logic [3:0] REQ_ADD_TAG    = 4'd7;
	localparam logic [3:0] REQ_REM_TAG    = 4'd8;
	localparam logic [3:0] REQ_SCAN       = 4'd9;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_DEAD = 2'd2;
	localparam logic [1:0] STAT_NONE = 2'd3;

	localparam logic [2:0] MARK_CREATE  = 3'b001;
	localparam logic [2:0] MARK_ALIVE   = 3'b010;
	localparam logic [2:0] MARK_DESTROY = 3'b100;

	typedef struct packed {
		logic alive_pre;
		logic alive_post;
		logic match_post;
		logic recycle;
	} eval_flags_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  id;
		logic [15:0] version;
		logic        alive;
		logic        match;
		logic [5:0]  count;
		logic [31:0] owned;
		logic [15:0] tags;
		logic        last;
	} result_t;
endpackage
`default_nettype wire

@@ rtl/ght_table.sv @@
// Slot store and free-slot FIFO of the handle table, each with one write and one
// registered read port. Depends on nothing but its parameters.
`default_nettype none
module ght_table #(
	parameter int ENTRY_COUNT    = 64,
	parameter int COMPONENT_BITS = 32,
	parameter int TAG_BITS       = 16,
	parameter int VERSION_BITS   = 16,
	parameter int IW             = 6
) (
	input  wire                      clk,
	input  wire                      ent_we,
	input  wire  [IW-1:0]            ent_addr,
	input  wire  [VERSION_BITS-1:0]  ent_wver,
	input  wire  [2:0]               ent_wmarks,
	input  wire  [COMPONENT_BITS-1:0] ent_wown,
	input  wire  [TAG_BITS-1:0]      ent_wtags,
	output logic [VERSION_BITS-1:0]  ent_rver,
	output logic [2:0]               ent_rmarks,
	output logic [COMPONENT_BITS-1:0] ent_rown,
	output logic [TAG_BITS-1:0]      ent_rtags,
	input  wire                      fifo_we,
	input  wire  [IW-1:0]            fifo_waddr,
	input  wire  [IW-1:0]            fifo_wdata,
	input  wire  [IW-1:0]            fifo_raddr,
	output logic [IW-1:0]            fifo_rdata
);
	localparam int EW = VERSION_BITS + 3 + COMPONENT_BITS + TAG_BITS;

	logic [EW-1:0] ent_mem [ENTRY_COUNT];
	logic [IW-1:0] fifo_mem [ENTRY_COUNT];
	logic [EW-1:0] ent_rd_q;

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_addr] <= {ent_wver, ent_wmarks, ent_wown, ent_wtags};
		end
		ent_rd_q <= ent_mem[ent_addr];
	end

	always_ff @(posedge clk) begin
		if (fifo_we) begin
			fifo_mem[fifo_waddr] <= fifo_wdata;
		end
		fifo_rdata <= fifo_mem[fifo_raddr];
	end

	assign {ent_rver, ent_rmarks, ent_rown, ent_rtags} = ent_rd_q;
endmodule
`default_nettype wire

@@ rtl/ght_entry_unit.sv @@
// Shared slot evaluation unit: liveness, match, next slot contents and owned count
// for every request kind. Depends on ght_pkg.
`default_nettype none
module ght_entry_unit #(
	parameter int COMPONENT_BITS = 32,
	parameter int TAG_BITS       = 16,
	parameter int VERSION_BITS   = 16,
	parameter int DISABLED_TAG   = 0
) (
	input  wire  [3:0]                req,
	input  wire                       own_handle,
	input  wire  [VERSION_BITS-1:0]   hver,
	input  wire  [COMPONENT_BITS-1:0] comps,
	input  wire  [TAG_BITS-1:0]       tags,
	input  wire  [3:0]                tidx,
	input  wire  [VERSION_BITS-1:0]   ver_in,
	input  wire  [2:0]                marks_in,
	input  wire  [COMPONENT_BITS-1:0] own_in,
	input  wire  [TAG_BITS-1:0]       tags_in,
	output logic [VERSION_BITS-1:0]   ver_out,
	output logic [2:0]                marks_out,
	output logic [COMPONENT_BITS-1:0] own_out,
	output logic [TAG_BITS-1:0]       tags_out,
	output logic [5:0]                count,
	output ght_pkg::eval_flags_t      flags
);
	localparam bit DIS_ON  = DISABLED_TAG < TAG_BITS;
	localparam int DIS_IDX = DIS_ON ? DISABLED_TAG : 0;
	localparam int PW      = $clog2(COMPONENT_BITS + 1);

	logic                    tidx_ok;
	logic [TAG_BITS-1:0]     tbit;
	logic [VERSION_BITS-1:0] hv_post;
	logic [PW-1:0]           pc;

	assign tidx_ok = 32'(tidx) < TAG_BITS;
	assign tbit    = TAG_BITS'(1) << tidx;

	always_comb begin
		ver_out   = ver_in;
		marks_out = marks_in;
		own_out   = own_in;
		tags_out  = tags_in;
		case (req)
			ght_pkg::REQ_CREATE: begin
				ver_out   = ver_in + VERSION_BITS'(1);
				marks_out = marks_in | ght_pkg::MARK_CREATE;
			end
			ght_pkg::REQ_DESTROY: marks_out = marks_in | ght_pkg::MARK_DESTROY;
			ght_pkg::REQ_COMMIT: begin
				if ((marks_in & ght_pkg::MARK_DESTROY) != 3'b0) begin
					marks_out = 3'b0;
					own_out   = '0;
					tags_out  = '0;
				end else if ((marks_in & ght_pkg::MARK_CREATE) != 3'b0) begin
					marks_out = ght_pkg::MARK_ALIVE;
				end
			end
			ght_pkg::REQ_ADD_COMPS: own_out = own_in | comps;
			ght_pkg::REQ_REM_COMPS: own_out = own_in & ~comps;
			ght_pkg::REQ_SET_TAGS:  tags_out = tags;
			ght_pkg::REQ_ADD_TAG:   if (tidx_ok) tags_out = tags_in | tbit;
			ght_pkg::REQ_REM_TAG:   if (tidx_ok) tags_out = tags_in & ~tbit;
			default: ;
		endcase
	end

	assign hv_post = own_handle ? ver_out : hver;

	assign flags.alive_pre = (ver_in == hver)
		&& ((marks_in & (ght_pkg::MARK_CREATE | ght_pkg::MARK_ALIVE)) != 3'b0)
		&& !(DIS_ON && tags_in[DIS_IDX]);
	assign flags.alive_post = (ver_out == hv_post)
		&& ((marks_out & (ght_pkg::MARK_CREATE | ght_pkg::MARK_ALIVE)) != 3'b0)
		&& !(DIS_ON && tags_out[DIS_IDX]);
	assign flags.match_post = flags.alive_post && ((comps & own_out) == comps)
		&& ((tags & tags_out) == tags);
	assign flags.recycle = (marks_in & ght_pkg::MARK_DESTROY) != 3'b0;

	always_comb begin
		pc = '0;
		for (int b = 0; b < COMPONENT_BITS; b++) begin
			pc = pc + PW'(own_out[b]);
		end
	end

	assign count = (32'(pc) > 63) ? 6'd63 : 6'(pc);
endmodule
`default_nettype wire

@@ rtl/generational_handle_table_unit.sv @@
// Generational handle table: a fresh create goes from request latch to evaluate and write, a
// recycled one first pops the free-slot FIFO and reads the slot; a destroy, query or edit runs
// request latch, slot read, evaluate and write, an unknown code goes to evaluate; commit and scan
// walk the used slots, a read and an evaluate each, through the single slot store read port,
// then a final step. in_stall is high from acceptance until the last result is registered.
`default_nettype none
module generational_handle_table_unit #(
	parameter int ENTRY_COUNT    = 64,
	parameter int COMPONENT_BITS = 32,
	parameter int TAG_BITS       = 16,
	parameter int VERSION_BITS   = 16,
	parameter int DISABLED_TAG   = 0
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [3:0]  req_type,
	input  wire  [5:0]  entity_id,
	input  wire  [15:0] entity_version,
	input  wire  [31:0] component_mask,
	input  wire  [15:0] tag_mask,
	input  wire  [3:0]  tag_index,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  status,
	output logic [5:0]  out_id,
	output logic [15:0] out_version,
	output logic        is_alive,
	output logic        matches_res,
	output logic [5:0]  component_count,
	output logic [31:0] owned_components,
	output logic [15:0] tags_out,
	output logic        last
);
	localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int CW = $clog2(ENTRY_COUNT + 1);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_FIFO     = 7'b0000010,
		ST_READ     = 7'b0000100,
		ST_EXEC     = 7'b0001000,
		ST_SWEEP_RD = 7'b0010000,
		ST_SWEEP_EX = 7'b0100000,
		ST_FINAL    = 7'b1000000
	} state_t;

	state_t                    state_q;
	logic [3:0]                req_q;
	logic [5:0]                id_q;
	logic [VERSION_BITS-1:0]   hv_q;
	logic [COMPONENT_BITS-1:0] comps_q;
	logic [TAG_BITS-1:0]       tags_q;
	logic [3:0]                tidx_q;
	logic [IW-1:0]             addr_q;
	logic                      fresh_q;
	logic                      full_q;
	logic [CW-1:0]             used_q;
	logic [IW-1:0]             head_q;
	logic [CW-1:0]             fill_q;
	logic                      pend_valid_q;
	ght_pkg::result_t          pend_q;
	ght_pkg::result_t          out_q;
	logic                      out_valid_q;

	logic [VERSION_BITS-1:0]   rd_ver, ev_ver, nv;
	logic [2:0]                rd_marks, ev_marks, nm;
	logic [COMPONENT_BITS-1:0] rd_own, ev_own, no;
	logic [TAG_BITS-1:0]       rd_tags, ev_tags, nt;
	logic [5:0]                cnt;
	ght_pkg::eval_flags_t      flags;
	logic [IW-1:0]             fifo_rdata;
	logic [IW-1:0]             tail;
	logic [CW:0]               tail_sum;

	logic              out_free, emit, advance, ent_we, fifo_we, used_hit, last_idx;
	logic              is_single;
	ght_pkg::result_t  res, ok_res, scan_res;

	assign ev_ver   = fresh_q ? '1 : rd_ver;
	assign ev_marks = fresh_q ? 3'b0 : rd_marks;
	assign ev_own   = fresh_q ? '0 : rd_own;
	assign ev_tags  = fresh_q ? '0 : rd_tags;

	ght_entry_unit #(
		.COMPONENT_BITS(COMPONENT_BITS), .TAG_BITS(TAG_BITS),
		.VERSION_BITS(VERSION_BITS), .DISABLED_TAG(DISABLED_TAG)
	) u_eval (
		.req(req_q),
		.own_handle(req_q == ght_pkg::REQ_CREATE || req_q == ght_pkg::REQ_SCAN),
		.hver(hv_q), .comps(comps_q), .tags(tags_q), .tidx(tidx_q),
		.ver_in(ev_ver), .marks_in(ev_marks), .own_in(ev_own), .tags_in(ev_tags),
		.ver_out(nv), .marks_out(nm), .own_out(no), .tags_out(nt),
		.count(cnt), .flags(flags)
	);

	assign tail_sum = (CW + 1)'(head_q) + (CW + 1)'(fill_q);
	assign tail = (tail_sum >= (CW + 1)'(ENTRY_COUNT))
		? IW'(tail_sum - (CW + 1)'(ENTRY_COUNT)) : IW'(tail_sum);

	ght_table #(
		.ENTRY_COUNT(ENTRY_COUNT), .COMPONENT_BITS(COMPONENT_BITS),
		.TAG_BITS(TAG_BITS), .VERSION_BITS(VERSION_BITS), .IW(IW)
	) u_table (
		.clk(clk),
		.ent_we(ent_we), .ent_addr(addr_q),
		.ent_wver(nv), .ent_wmarks(nm), .ent_wown(no), .ent_wtags(nt),
		.ent_rver(rd_ver), .ent_rmarks(rd_marks), .ent_rown(rd_own), .ent_rtags(rd_tags),
		.fifo_we(fifo_we), .fifo_waddr(tail), .fifo_wdata(addr_q),
		.fifo_raddr(head_q), .fifo_rdata(fifo_rdata)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign used_hit  = (CW + 6)'(id_q) < (CW + 6)'(used_q);
	assign last_idx  = (CW'(addr_q) + CW'(1)) == used_q;
	assign is_single = req_q inside {ght_pkg::REQ_DESTROY, ght_pkg::REQ_QUERY,
		ght_pkg::REQ_ADD_COMPS, ght_pkg::REQ_REM_COMPS, ght_pkg::REQ_SET_TAGS,
		ght_pkg::REQ_ADD_TAG, ght_pkg::REQ_REM_TAG};

	always_comb begin
		ok_res.status  = ght_pkg::STAT_OK;
		ok_res.id      = 6'(addr_q);
		ok_res.version = 16'(nv);
		ok_res.alive   = flags.alive_post;
		ok_res.match   = flags.match_post;
		ok_res.count   = cnt;
		ok_res.owned   = 32'(no);
		ok_res.tags    = 16'(nt);
		ok_res.last    = 1'b1;
		scan_res       = ok_res;
		scan_res.last  = 1'b0;
	end

	always_comb begin
		emit    = 1'b0;
		advance = 1'b0;
		ent_we  = 1'b0;
		fifo_we = 1'b0;
		res     = '0;
		res.last = 1'b1;
		case (state_q)
			ST_EXEC: begin
				if (out_free) begin
					emit = 1'b1;
					if (req_q == ght_pkg::REQ_CREATE && !full_q) begin
						ent_we = 1'b1;
						res    = ok_res;
					end else if (req_q == ght_pkg::REQ_CREATE) begin
						res.status = ght_pkg::STAT_FULL;
					end else if (is_single && used_hit && flags.alive_pre) begin
						ent_we = 1'b1;
						res    = ok_res;
					end else if (is_single) begin
						res.status  = ght_pkg::STAT_DEAD;
						res.id      = id_q;
						res.version = used_hit ? 16'(rd_ver) : 16'd0;
					end else begin
						res.status = ght_pkg::STAT_NONE;
					end
				end
			end
			ST_SWEEP_EX: begin
				if (req_q == ght_pkg::REQ_COMMIT) begin
					ent_we  = 1'b1;
					fifo_we = flags.recycle && (fill_q < CW'(ENTRY_COUNT));
					advance = 1'b1;
				end else if (flags.match_post && pend_valid_q) begin
					if (out_free) begin
						emit    = 1'b1;
						res     = pend_q;
						advance = 1'b1;
					end
				end else begin
					advance = 1'b1;
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					emit = 1'b1;
					if (req_q == ght_pkg::REQ_SCAN) begin
						if (pend_valid_q) begin
							res      = pend_q;
							res.last = 1'b1;
						end else begin
							res.status = ght_pkg::STAT_NONE;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= '0;
			head_q       <= '0;
			fill_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			fresh_q      <= 1'b0;
			full_q       <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						fresh_q      <= 1'b0;
						full_q       <= 1'b0;
						pend_valid_q <= 1'b0;
						case (req_type)
							ght_pkg::REQ_CREATE: begin
								if (fill_q != '0) begin
									state_q <= ST_FIFO;
								end else if (used_q < CW'(ENTRY_COUNT)) begin
									fresh_q <= 1'b1;
									state_q <= ST_EXEC;
								end else begin
									full_q  <= 1'b1;
									state_q <= ST_EXEC;
								end
							end
							ght_pkg::REQ_COMMIT, ght_pkg::REQ_SCAN: begin
								state_q <= (used_q == '0) ? ST_FINAL : ST_SWEEP_RD;
							end
							ght_pkg::REQ_DESTROY, ght_pkg::REQ_QUERY,
							ght_pkg::REQ_ADD_COMPS, ght_pkg::REQ_REM_COMPS,
							ght_pkg::REQ_SET_TAGS, ght_pkg::REQ_ADD_TAG,
							ght_pkg::REQ_REM_TAG: state_q <= ST_READ;
							default: state_q <= ST_EXEC;
						endcase
					end
				end
				ST_FIFO: begin
					head_q  <= (head_q == IW'(ENTRY_COUNT - 1)) ? '0 : head_q + IW'(1);
					fill_q  <= fill_q - CW'(1);
					state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (emit) begin
						if (ent_we && fresh_q) begin
							used_q <= used_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP_RD: state_q <= ST_SWEEP_EX;
				ST_SWEEP_EX: begin
					if (advance) begin
						if (fifo_we) begin
							fill_q <= fill_q + CW'(1);
						end
						if (req_q == ght_pkg::REQ_SCAN && flags.match_post) begin
							pend_valid_q <= 1'b1;
						end
						state_q <= last_idx ? ST_FINAL : ST_SWEEP_RD;
					end
				end
				ST_FINAL: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					req_q   <= req_type;
					id_q    <= entity_id;
					hv_q    <= VERSION_BITS'(entity_version);
					comps_q <= COMPONENT_BITS'(component_mask);
					tags_q  <= TAG_BITS'(tag_mask);
					tidx_q  <= tag_index;
					if (req_type == ght_pkg::REQ_CREATE) begin
						addr_q <= IW'(used_q);
					end else if (req_type == ght_pkg::REQ_COMMIT
						|| req_type == ght_pkg::REQ_SCAN) begin
						addr_q <= '0;
					end else begin
						addr_q <= IW'(entity_id);
					end
				end
			end
			ST_FIFO: addr_q <= fifo_rdata;
			ST_SWEEP_EX: begin
				if (advance) begin
					if (flags.match_post) begin
						pend_q <= scan_res;
					end
					if (!last_idx) begin
						addr_q <= addr_q + IW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	assign in_stall         = state_q != ST_IDLE;
	assign out_valid        = out_valid_q;
	assign status           = out_q.status;
	assign out_id           = out_q.id;
	assign out_version      = out_q.version;
	assign is_alive         = out_q.alive;
	assign matches_res      = out_q.match;
	assign component_count  = out_q.count;
	assign owned_components = out_q.owned;
	assign tags_out         = out_q.tags;
	assign last             = out_q.last;

	a_fill_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= used_q)
		else $error("free list holds more slots than are in use");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(ENTRY_COUNT))
		else $error("slot count beyond table size");
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE))
		else $error("request accepted without leaving idle");
	a_emit_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !emit)
		else $error("result overwrote a stalled result");
endmodule
`default_nettype wire
